// ----- hw/rtl/icmp_echo_responder_macros.svh -----
// assertion helpers shared by the responder modules
`ifndef ICMP_ECHO_RESPONDER_MACROS_SVH
`define ICMP_ECHO_RESPONDER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define IECHO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never occur
`define IECHO_NEVER(lbl, cond, msg) \
  `IECHO_ASSERT(lbl, !(cond), msg)
`else
`define IECHO_ASSERT(lbl, prop, msg)
`define IECHO_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hw/rtl/iecho_pkg.sv -----
package iecho_pkg;

  // default size of the packet store in bytes
  localparam int BUFFER_BYTES_DEF = 2048;

  // depth of the fetch request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] ECHO_REQUEST_TYPE = 8'd8;

  // byte offsets inside the icmp message
  localparam int ICMP_OFS_TYPE = 0;
  localparam int ICMP_OFS_CKHI = 2;
  localparam int ICMP_OFS_CKLO = 3;

  // byte positions inside the ipv4 header
  localparam int IP_POS_LEN_HI = 2;
  localparam int IP_POS_LEN_LO = 3;
  // first position past the length field
  localparam int IP_POS_BODY = 4;

  // one resolved fetch request
  typedef struct packed {
    logic       use_mem;  // byte comes from the packet store
    logic [7:0] data;     // byte when not read from the store
    logic       last;
    logic       rvalid;
  } fetch_req_t;

endpackage

// ----- hw/rtl/iecho_ram.sv -----
module iecho_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/iecho_fifo.sv -----
`include "icmp_echo_responder_macros.svh"

module iecho_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNTW-1:0]  count_r;

  assign full     = (count_r == CNTW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `IECHO_NEVER(a_fifo_no_overflow, push && full && !pop, "fetch queue overflow")
  `IECHO_NEVER(a_fifo_no_underflow, pop && empty, "fetch queue underflow")

endmodule

// ----- hw/rtl/iecho_front.sv -----
`include "icmp_echo_responder_macros.svh"

module iecho_front import iecho_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_command,
  input  logic [7:0]    in_data_byte,
  input  logic          in_end_of_packet,
  input  logic          back_busy,
  input  logic          q_full,
  output logic          push,
  output fetch_req_t    push_req,
  output logic [AW-1:0] push_addr,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata
);

  localparam logic [16:0] BUF_LIM = 17'(BUFFER_BYTES);

  typedef enum logic [1:0] {ST_RUN, ST_SUM, ST_FOLD1, ST_FOLD2} state_t;

  state_t      state_r;
  logic        echo_en_r;
  logic        closed_r;
  logic [CW-1:0] cnt_r;
  logic [5:0]  hdr_r;
  logic [15:0] total_r;
  logic [31:0] acc_r;
  logic [7:0]  b1_r;
  logic [7:0]  type_r;
  logic        type_seen_r;
  logic        ok_r;
  logic [15:0] ck_r;
  logic        pending_r;
  logic [CW-1:0] rp_r;

  logic        accept;
  logic        load_acc;
  logic        fetch_acc;

  // load side: values as seen by this byte (new packet starts from zero)
  logic [CW-1:0] cnt_cur;
  logic [5:0]  hdr_cur;
  logic [15:0] total_cur;
  logic [31:0] acc_cur;
  logic [7:0]  b1_cur;
  logic        type_seen_cur;
  logic [16:0] pos_ld;
  logic        store_ok;
  logic [5:0]  hdr_nxt;
  logic [15:0] total_nxt;
  logic        sum_hit;
  logic [31:0] acc_nxt;

  // fetch side
  logic [15:0] len_w;
  logic [16:0] rp_ext;
  logic [16:0] pos_rd;
  logic        active;
  logic        close_ok;
  logic [16:0] fold;

  assign accept    = in_valid && in_ready;
  assign load_acc  = accept && !in_command;
  assign fetch_acc = accept && in_command;

  // loads wait until earlier fetches have read the store
  assign in_ready = (state_r == ST_RUN) && (in_command ? !q_full : !back_busy);

  always_comb begin
    cnt_cur       = closed_r ? '0 : cnt_r;
    hdr_cur       = closed_r ? '0 : hdr_r;
    total_cur     = closed_r ? '0 : total_r;
    acc_cur       = closed_r ? '0 : acc_r;
    b1_cur        = closed_r ? '0 : b1_r;
    type_seen_cur = closed_r ? 1'b0 : type_seen_r;
    pos_ld        = 17'(cnt_cur);
    store_ok      = (pos_ld < BUF_LIM);

    hdr_nxt   = (pos_ld == '0) ? {in_data_byte[3:0], 2'b00} : hdr_cur;
    total_nxt = total_cur;
    if (pos_ld == 17'(IP_POS_LEN_HI)) begin
      total_nxt = {in_data_byte, total_cur[7:0]};
    end else if (pos_ld == 17'(IP_POS_LEN_LO)) begin
      total_nxt = {total_cur[15:8], in_data_byte};
    end

    // bytes of the icmp body past the length field; type and checksum count as zero
    sum_hit = store_ok && (pos_ld >= 17'(IP_POS_BODY)) && (pos_ld >= 17'(hdr_cur))
              && (pos_ld < 17'(total_cur))
              && (pos_ld != 17'(hdr_cur) + 17'(ICMP_OFS_TYPE))
              && (pos_ld != 17'(hdr_cur) + 17'(ICMP_OFS_CKHI))
              && (pos_ld != 17'(hdr_cur) + 17'(ICMP_OFS_CKLO));
    acc_nxt = acc_cur;
    if (sum_hit) begin
      acc_nxt = acc_cur + (pos_ld[0] ? {24'd0, in_data_byte} : {16'd0, in_data_byte, 8'd0});
    end
  end

  assign ram_we    = load_acc && store_ok;
  assign ram_waddr = cnt_cur[AW-1:0];
  assign ram_wdata = in_data_byte;

  assign len_w  = total_r - {10'd0, hdr_r};
  assign rp_ext = 17'(rp_r);
  assign pos_rd = 17'(hdr_r) + rp_ext;
  assign active = pending_r && (rp_ext < 17'(len_w));

  assign close_ok = echo_en_r && (total_r >= {10'd0, hdr_r}) && (17'(total_r) <= BUF_LIM)
                    && (len_w != '0) && type_seen_r && (type_r == ECHO_REQUEST_TYPE);

  assign fold = 17'(acc_r[31:16]) + 17'(acc_r[15:0]);

  always_comb begin
    push_req  = '0;
    push_addr = pos_rd[AW-1:0];
    push      = fetch_acc;
    if (active) begin
      push_req.rvalid = 1'b1;
      push_req.last   = (rp_ext + 17'd1 == 17'(len_w));
      if (rp_ext == 17'(ICMP_OFS_TYPE)) begin
        push_req.data = 8'd0;
      end else if (rp_ext == 17'(ICMP_OFS_CKHI)) begin
        push_req.data = ck_r[15:8];
      end else if (rp_ext == 17'(ICMP_OFS_CKLO)) begin
        push_req.data = ck_r[7:0];
      end else begin
        push_req.use_mem = (pos_rd < 17'(cnt_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      echo_en_r   <= 1'b1;
      closed_r    <= 1'b1;
      cnt_r       <= '0;
      hdr_r       <= '0;
      total_r     <= '0;
      acc_r       <= '0;
      b1_r        <= '0;
      type_r      <= '0;
      type_seen_r <= 1'b0;
      ok_r        <= 1'b0;
      ck_r        <= '0;
      pending_r   <= 1'b0;
      rp_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        echo_en_r <= cfg_wr_data;
      end
      unique case (state_r)
        ST_RUN: begin
          if (load_acc) begin
            closed_r    <= in_end_of_packet;
            pending_r   <= 1'b0;
            rp_r        <= '0;
            hdr_r       <= store_ok ? hdr_nxt : hdr_cur;
            total_r     <= store_ok ? total_nxt : total_cur;
            acc_r       <= acc_nxt;
            cnt_r       <= store_ok ? cnt_cur + 1'b1 : cnt_cur;
            b1_r        <= (store_ok && pos_ld == 17'd1) ? in_data_byte : b1_cur;
            type_seen_r <= type_seen_cur || (store_ok && pos_ld == 17'(hdr_nxt));
            if (store_ok && pos_ld == 17'(hdr_nxt)) begin
              type_r <= in_data_byte;
            end
            if (in_end_of_packet) begin
              state_r <= ST_SUM;
            end
          end else if (fetch_acc && active) begin
            rp_r <= rp_r + 1'b1;
          end
        end
        ST_SUM: begin
          // byte one lies in the icmp message only when the header is empty
          acc_r   <= acc_r + (((hdr_r == '0) && (total_r > 16'd1)) ? {24'd0, b1_r} : 32'd0);
          ok_r    <= close_ok;
          state_r <= ST_FOLD1;
        end
        ST_FOLD1: begin
          acc_r   <= 32'(fold);
          state_r <= ST_FOLD2;
        end
        ST_FOLD2: begin
          ck_r      <= ~fold[15:0];
          pending_r <= ok_r;
          state_r   <= ST_RUN;
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  `IECHO_ASSERT(a_front_sum_after_eop,
                (state_r == ST_SUM) |-> $past(load_acc && in_end_of_packet),
                "checksum close without end of packet")
  `IECHO_ASSERT(a_front_pending_len,
                pending_r |-> ((len_w != '0) && (17'(total_r) <= BUF_LIM)),
                "reply armed with bad length")
  `IECHO_NEVER(a_front_idle_on_close,
               (state_r != ST_RUN) && accept,
               "request taken while closing packet")

endmodule

// ----- hw/rtl/iecho_back.sv -----
`include "icmp_echo_responder_macros.svh"

module iecho_back import iecho_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  fetch_req_t    q_req,
  input  logic [AW-1:0] q_addr,
  output logic          q_pop,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output logic          back_busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_reply_byte,
  output logic          out_reply_last,
  output logic          out_reply_valid
);

  logic       s1_v_r;
  fetch_req_t s1_req_r;
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_rv_r;
  logic       out_free;

  assign out_free  = !out_v_r || out_ready;
  assign q_pop     = !q_empty && (!s1_v_r || out_free);
  assign ram_re    = q_pop;
  assign ram_raddr = q_addr;
  assign back_busy = !q_empty || s1_v_r;

  assign out_valid       = out_v_r;
  assign out_reply_byte  = out_byte_r;
  assign out_reply_last  = out_last_r;
  assign out_reply_valid = out_rv_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_req_r <= q_req;
    end
    if (out_free && s1_v_r) begin
      out_byte_r <= s1_req_r.use_mem ? ram_rdata : s1_req_r.data;
      out_last_r <= s1_req_r.last;
      out_rv_r   <= s1_req_r.rvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_v_r <= 1'b1;
      end else if (out_free) begin
        s1_v_r <= 1'b0;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // only store reads of written bytes carry data worth holding
  `IECHO_ASSERT(a_back_rdata_hold,
                (s1_v_r && !out_free && s1_req_r.use_mem) |=> $stable(ram_rdata),
                "store read data lost while stalled")

endmodule

// ----- hw/rtl/icmp_echo_responder.sv -----
// icmp echo responder: bytes of a received ipv4 packet are loaded one per
// request (command 0) into a packet store of BUFFER_BYTES bytes while the
// header length, total length and the icmp checksum sum are collected on the
// fly. the request that carries end_of_packet closes the packet; the block
// then adds in the deferred byte and folds the sum in its closing states, and
// takes no request during that time. if echo_enable is set, the
// type byte is an echo request and the lengths are sane, a reply is armed:
// type 0, code and data kept, checksum recomputed. each fetch request
// (command 1) returns exactly one result, the next reply byte, or a result
// with reply_valid low when nothing is pending or the reply is used up.
// a load after end_of_packet starts a new packet and drops any pending reply.
// rate: one request per cycle for loads and for fetches while the block is
// not holding requests off; none is taken while a packet closes. a load waits
// while earlier fetches are still queued for the single store read port or
// held in its read stage. a fetch result is registered in the store read
// stage and then in the result register; a four-entry queue sits between the
// request side and the store read stage, so a stalled result side holds
// fetches off only once that queue is full. the store needs no clearing pass
// after reset.
module icmp_echo_responder import iecho_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration: echo_enable
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_packet,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_reply_byte,
  output logic       out_reply_last,
  output logic       out_reply_valid
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int QW = $bits(fetch_req_t) + AW;

  // request side to queue
  logic          push;
  fetch_req_t    push_req;
  logic [AW-1:0] push_addr;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic [QW-1:0] q_data;
  fetch_req_t    q_req;
  logic [AW-1:0] q_addr;

  // packet store ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          back_busy;

  assign q_req  = fetch_req_t'(q_data[QW-1:AW]);
  assign q_addr = q_data[AW-1:0];

  // front: takes requests, loads the store, keeps the checksum, resolves fetches
  iecho_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .in_end_of_packet(in_end_of_packet),
    .back_busy       (back_busy),
    .q_full          (q_full),
    .push            (push),
    .push_req        (push_req),
    .push_addr       (push_addr),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata)
  );

  // resolved fetch requests waiting for the store read port
  iecho_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_req, push_addr}),
    .pop      (q_pop),
    .pop_data (q_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  // packet store
  iecho_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // back: reads the store and drives the result register
  iecho_back #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_req          (q_req),
    .q_addr         (q_addr),
    .q_pop          (q_pop),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .back_busy      (back_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reply_byte (out_reply_byte),
    .out_reply_last (out_reply_last),
    .out_reply_valid(out_reply_valid)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import iecho_pkg::*;

  localparam int BUF_BYTES = BUFFER_BYTES_DEF;
  // request commands
  localparam bit CMD_LOAD  = 1'b0;
  localparam bit CMD_FETCH = 1'b1;
  localparam logic [7:0] ECHO_REPLY_TYPE = 8'h00;
  // cycles to let the block finish closing a packet after the last result
  localparam int SETTLE_CYCLES = 16;

  // one result as seen on the output channel
  typedef struct packed {
    logic [7:0] rbyte;
    logic       last;
    logic       rvalid;
  } reply_t;

  localparam reply_t IDLE_FETCH = '0;

  // one row of the directed table; typed rows carry their own expected reply
  typedef struct {
    bit         cmd;
    logic [7:0] data;
    bit         eop;
    bit         typed;
    reply_t     rep;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_command = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_packet = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_reply_byte;
  logic       out_reply_last;
  logic       out_reply_valid;

  icmp_echo_responder #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .in_end_of_packet(in_end_of_packet),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reply_byte  (out_reply_byte),
    .out_reply_last  (out_reply_last),
    .out_reply_valid (out_reply_valid)
  );

  always #2 clk = ~clk;

  // run guard, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // responder state as the testbench tracks it
  // ---------------------------------------------------------------------------
  logic [7:0]  pkt_mem [BUF_BYTES];
  int unsigned rx_count = 0;     // bytes stored for the current packet
  int unsigned hdr_len = 0;      // ipv4 header length in bytes
  int unsigned tot_len = 0;      // ipv4 total length field
  logic [15:0] reply_ck = '0;    // checksum to put in the reply
  bit          reply_armed = 1'b0;
  int unsigned rd_pos = 0;       // next reply byte to hand out
  bit          pkt_open = 1'b0;  // cleared: next load starts a new packet
  bit          echo_en = 1'b1;

  reply_t      reply_queue [$];  // replies still owed by the block
  int unsigned err_count = 0;
  int unsigned req_count = 0;
  int          burst_left = 0;

  // stored byte, zero anywhere past what was received
  function automatic logic [7:0] rx_byte(input int unsigned pos);
    if (pos < rx_count && pos < BUF_BYTES) return pkt_mem[pos];
    return 8'h00;
  endfunction

  // end of packet: decide whether a reply is armed and work out its checksum
  function automatic void close_packet();
    int unsigned len;
    logic [31:0] acc;
    logic [7:0]  b;
    pkt_open = 1'b0;
    reply_armed = 1'b0;
    rd_pos = 0;
    if (!echo_en) return;
    if (tot_len < hdr_len || tot_len > BUF_BYTES) return;
    len = tot_len - hdr_len;
    if (len == 0) return;
    if (rx_byte(hdr_len) != ECHO_REQUEST_TYPE) return;
    acc = '0;
    for (int unsigned o = 0; o < len; o++) begin
      // type and checksum bytes enter the sum as zero
      if (o == ICMP_OFS_TYPE || o == ICMP_OFS_CKHI || o == ICMP_OFS_CKLO) b = 8'h00;
      else b = rx_byte(hdr_len + o);
      // even offsets are the high byte of a word, an odd tail pads with zero
      acc += o[0] ? {24'h0, b} : {16'h0, b, 8'h00};
    end
    acc = (acc >> 16) + (acc & 32'hffff);
    acc = (acc >> 16) + (acc & 32'hffff);
    reply_ck = ~acc[15:0];
    reply_armed = 1'b1;
  endfunction

  function automatic void load_byte(input logic [7:0] data, input bit eop);
    if (!pkt_open) begin
      // first byte of a new packet drops whatever reply was left
      pkt_open = 1'b1;
      rx_count = 0;
      hdr_len = 0;
      tot_len = 0;
      reply_armed = 1'b0;
      rd_pos = 0;
    end
    if (rx_count < BUF_BYTES) begin
      pkt_mem[rx_count] = data;
      if (rx_count == 0) hdr_len = data[3:0] * 4;
      else if (rx_count == IP_POS_LEN_HI) tot_len[15:8] = data;
      else if (rx_count == IP_POS_LEN_LO) tot_len[7:0] = data;
      rx_count++;
    end
    if (eop) close_packet();
  endfunction

  // reply byte that the next fetch request must return
  function automatic reply_t next_reply();
    reply_t      rep;
    int unsigned len;
    rep = IDLE_FETCH;
    if (!reply_armed) return rep;
    len = tot_len - hdr_len;
    if (rd_pos >= len) return rep;
    case (rd_pos)
      ICMP_OFS_TYPE: rep.rbyte = ECHO_REPLY_TYPE;
      ICMP_OFS_CKHI: rep.rbyte = reply_ck[15:8];
      ICMP_OFS_CKLO: rep.rbyte = reply_ck[7:0];
      default:       rep.rbyte = rx_byte(hdr_len + rd_pos);
    endcase
    rep.last = (rd_pos + 1 == len);
    rep.rvalid = 1'b1;
    rd_pos++;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  task automatic send_req(input bit cmd, input logic [7:0] data, input bit eop,
                          input bit typed, input reply_t typed_rep);
    int gap;
    reply_t pred;
    if (burst_left == 0) begin
      // a quarter of the bursts follow on with no gap at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_command = cmd;
    in_data_byte = data;
    in_end_of_packet = eop;
    do @(posedge clk); while (!in_ready);
    req_count++;
    if (cmd == CMD_FETCH) begin
      pred = next_reply();
      reply_queue.push_back(typed ? typed_rep : pred);
    end else begin
      load_byte(data, eop);
    end
  endtask

  // drop valid at the next falling edge
  task automatic hold_off();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // pause the sender until every owed reply is in and the block has settled
  task automatic wait_replies();
    hold_off();
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while nothing is in flight
  task automatic set_echo(input bit en);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = en;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    echo_en = en;
  endtask

  // one received packet followed by its fetches; big overruns the store
  task automatic send_packet(input bit big);
    int unsigned ihl, hdr, ilen, sent, nfetch, r;
    logic [15:0] len_field;
    logic [7:0]  b;
    bit          echo_req;
    // mostly short headers, now and then any header length including zero
    ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 6);
    hdr = ihl * 4;
    r = $urandom_range(0, 99);
    if (big) ilen = $urandom_range(0, 1) ? BUF_BYTES - hdr : $urandom_range(4, 40);
    else if (r < 6) ilen = $urandom_range(0, 3);       // icmp message cut short
    else if (r < 92) ilen = $urandom_range(4, 48);
    else ilen = $urandom_range(49, 300);
    len_field = 16'(hdr + ilen);
    // stated length that disagrees with the real one now and then
    if (!big && $urandom_range(0, 9) == 0) len_field = 16'($urandom_range(0, 16'hffff));
    if (big) sent = BUF_BYTES + $urandom_range(1, 6);
    else if ($urandom_range(0, 9) == 0) sent = $urandom_range(1, hdr + ilen + 4);
    else sent = (hdr + ilen == 0) ? 1 : hdr + ilen;
    echo_req = big || ($urandom_range(0, 9) != 0);

    for (int unsigned p = 0; p < sent; p++) begin
      b = 8'($urandom_range(0, 255));
      if (p == 0) b[3:0] = ihl[3:0];
      else if (p == IP_POS_LEN_HI) b = len_field[15:8];
      else if (p == IP_POS_LEN_LO) b = len_field[7:0];
      else if (p == hdr && echo_req) b = ECHO_REQUEST_TYPE;
      send_req(CMD_LOAD, b, p == sent - 1, 1'b0, IDLE_FETCH);
      // stray fetch in the middle of loading sees no reply
      if (p + 1 < sent && $urandom_range(0, 49) == 0)
        send_req(CMD_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'b0, IDLE_FETCH);
    end

    // usually the whole reply and a bit past its end, sometimes only part
    if ($urandom_range(0, 6) == 0) nfetch = $urandom_range(0, ilen);
    else nfetch = ilen + $urandom_range(0, 2);
    repeat (nfetch)
      send_req(CMD_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'b0, IDLE_FETCH);
  endtask

  // mostly whole packets, some noise, and an occasional full pause
  task automatic run_traffic(input int unsigned n_reqs);
    int unsigned stop;
    int unsigned pick;
    stop = req_count + n_reqs;
    while (req_count < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 $urandom_range(0, 3) == 0, 1'b0, IDLE_FETCH);
      else if (pick < 10)
        wait_replies();
      else
        send_packet(1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: modes of always ready, coin flips and long stalls
  // ---------------------------------------------------------------------------
  int rx_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    case (rx_mode)
      0: out_ready = 1'b1;
      1: out_ready = 1'($urandom_range(0, 1));
      default: begin
        if (stall_left != 0) begin
          out_ready = 1'b0;
          stall_left--;
        end else begin
          out_ready = 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(5, 20);
        end
      end
    endcase
  end

  task automatic note_mismatch(input string what, input reply_t want, input reply_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t mismatch, %s: expected byte %02h last %0b valid %0b, %s",
               $realtime, what, want.rbyte, want.last, want.rvalid,
               $sformatf("got byte %02h last %0b valid %0b",
                         got.rbyte, got.last, got.rvalid));
  endtask

  // compare each accepted result with the oldest owed reply
  always @(posedge clk) begin : check_replies
    reply_t got;
    reply_t want;
    got = '{out_reply_byte, out_reply_last, out_reply_valid};
    if (rst_n && out_valid && out_ready) begin
      if (reply_queue.size() == 0) begin
        note_mismatch("result with no fetch outstanding", IDLE_FETCH, got);
      end else begin
        want = reply_queue.pop_front();
        if (want.rbyte !== got.rbyte || want.last !== got.last ||
            want.rvalid !== got.rvalid)
          note_mismatch("reply", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed table, then random phases at both echo settings
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [23];

  initial begin
    dir_rows = '{
      // fetch straight out of reset: nothing pending
      '{CMD_FETCH, 8'h00, 1'b0, 1'b1, IDLE_FETCH},
      // echo request, 4 byte header, total 9: odd icmp length pads the sum
      '{CMD_LOAD,  8'h41, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'h00, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'h00, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'h09, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'h08, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'h00, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'hff, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'hff, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'ha5, 1'b1, 1'b0, IDLE_FETCH},
      // type turns into zero, code kept
      '{CMD_FETCH, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{CMD_FETCH, 8'hff, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
      // recomputed checksum comes from the tracked state
      '{CMD_FETCH, 8'h00, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_FETCH, 8'h00, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_FETCH, 8'h00, 1'b0, 1'b1, '{8'ha5, 1'b1, 1'b1}},
      // reply used up
      '{CMD_FETCH, 8'h00, 1'b0, 1'b1, IDLE_FETCH},
      // one byte packet: 60 byte header, total length below it
      '{CMD_LOAD,  8'hff, 1'b1, 1'b0, IDLE_FETCH},
      '{CMD_FETCH, 8'h00, 1'b0, 1'b1, IDLE_FETCH},
      // total length 0xffff, far past the store
      '{CMD_LOAD,  8'h41, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'hff, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'hff, 1'b0, 1'b0, IDLE_FETCH},
      '{CMD_LOAD,  8'hff, 1'b1, 1'b0, IDLE_FETCH},
      '{CMD_FETCH, 8'h00, 1'b0, 1'b1, IDLE_FETCH}
    };

    // synchronous reset, released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_echo(1'b1);
    foreach (dir_rows[i])
      send_req(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].eop,
               dir_rows[i].typed, dir_rows[i].rep);
    wait_replies();

    // a packet longer than the store, then ordinary traffic
    send_packet(1'b1);
    run_traffic(600);
    wait_replies();

    // echo off: every packet is ignored, fetches come back empty
    set_echo(1'b0);
    run_traffic(350);
    wait_replies();

    set_echo(1'b1);
    run_traffic(900);

    // drain and let the last packet close out
    hold_off();
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && reply_queue.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
